[src/sccbbe_pkg.sv]
// ---------------------------------------------------------------------------
// SCCB master bit engine package
// Shared widths, command codes and sequencer state encoding.
// ---------------------------------------------------------------------------
package sccbbe_pkg;

   localparam int OP_W      = 3;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 4;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] PHASE_RESET  = 8'd4;
   localparam logic [BYTE_W-1:0] SAMPLE_RESET = 8'd2;
   localparam logic [CNT_W-1:0]  BITS_PER_BYTE = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_ACK   = 3'd5
   } op_type;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_START1  = 15'b000000000000010,
      ST_START2  = 15'b000000000000100,
      ST_STOP1   = 15'b000000000001000,
      ST_STOP2   = 15'b000000000010000,
      ST_WRISE   = 15'b000000000100000,
      ST_WFALL   = 15'b000000001000000,
      ST_WNEXT   = 15'b000000010000000,
      ST_RRISE   = 15'b000000100000000,
      ST_RSAMPLE = 15'b000001000000000,
      ST_RFALL   = 15'b000010000000000,
      ST_RNEXT   = 15'b000100000000000,
      ST_ARISE   = 15'b001000000000000,
      ST_AFALL   = 15'b010000000000000,
      ST_ADONE   = 15'b100000000000000
   } step_type;

endpackage

[src/sccb_master_bit_engine_top.sv]
// ---------------------------------------------------------------------------
// SCCB master bit engine
// Two-wire master line sequencer advanced by one timebase tick per request.
// ---------------------------------------------------------------------------
// Each request on the req_ channel is one tick of a one-microsecond timebase.
// It carries a command (start, stop, write byte, read byte, master ACK),
// which is taken only while the engine is idle, the byte to send and the
// sampled SDA level. Every request gives exactly one response on the rsp_
// channel with the SCL, SDA and SDA-enable levels after that tick, a busy
// flag, the last received byte and a flag marking the tick a read completes.
// Each response is registered as its request is taken. One request is taken in
// every cycle: the sequencer state doubles as the response register, so the
// tick update and the response handover happen on the same clock edge.
// When the receiver stalls, req_tready falls and the response and state hold.
// The csr_ port sets the half-bit phase length and the read sample point;
// write it only while idle. After reset both lines are high and driven, the
// sequencer is idle, the received byte is zero and no response is pending.
// ---------------------------------------------------------------------------
module sccb_master_bit_engine_top
   import sccbbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // op[2:0], tx_data[10:3], sda_in[11]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // scl[0], sda_out[1], sda_oe[2],
                                             // busy_res[3], rx_data[11:4], rx_valid[12]
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   logic [BYTE_W-1:0] phase_ff, sample_ff;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in_lvl;
   logic              drive_ff, drive_in;
   step_type          step_ff, step_in;
   logic [CNT_W-1:0]  bit_ff, bit_in;
   logic [BYTE_W-1:0] wait_ff, wait_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BYTE_W-1:0] rx_hold_ff, rx_hold_in;
   logic              rx_valid_ff, rx_valid_in;
   logic              rsp_valid_ff;

   logic              accept;
   op_type            req_op;
   logic [BYTE_W-1:0] req_tx;
   logic              req_sda;
   logic [BYTE_W-1:0] eff_phase, eff_sample, phase_m1, sample_m1, extra_m1;
   logic [CNT_W-1:0]  bit_inc;

   assign req_op  = op_type'(req_tdata[OP_W-1:0]);
   assign req_tx  = req_tdata[OP_W +: BYTE_W];
   assign req_sda = req_tdata[OP_W+BYTE_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign eff_phase  = (phase_ff == '0) ? BYTE_W'(1) : phase_ff;
   assign eff_sample = (sample_ff == '0) ? BYTE_W'(1) : sample_ff;
   assign phase_m1   = eff_phase - BYTE_W'(1);
   assign sample_m1  = eff_sample - BYTE_W'(1);
   assign extra_m1   = eff_phase - eff_sample - BYTE_W'(1);
   assign bit_inc    = bit_ff + CNT_W'(1);

   always_comb begin
      scl_in      = scl_ff;
      sda_in_lvl  = sda_ff;
      drive_in    = drive_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      wait_in     = wait_ff;
      shift_in    = shift_ff;
      rx_hold_in  = rx_hold_ff;
      rx_valid_in = 1'b0;
      if (step_ff == ST_IDLE) begin
         unique case (req_op)
            OP_START: begin
               bit_in = '0; scl_in = 1'b1; sda_in_lvl = 1'b1;
               step_in = ST_START1; wait_in = phase_m1;
            end
            OP_STOP: begin
               bit_in = '0; scl_in = 1'b0; sda_in_lvl = 1'b0;
               step_in = ST_STOP1; wait_in = phase_m1;
            end
            OP_WRITE: begin
               bit_in = '0; scl_in = 1'b0;
               sda_in_lvl = req_tx[BYTE_W-1];
               shift_in = {req_tx[BYTE_W-2:0], 1'b0};
               step_in = ST_WRISE; wait_in = phase_m1;
            end
            OP_READ: begin
               bit_in = '0; drive_in = 1'b0; scl_in = 1'b0; shift_in = '0;
               step_in = ST_RRISE; wait_in = phase_m1;
            end
            OP_ACK: begin
               bit_in = '0; scl_in = 1'b0; sda_in_lvl = 1'b0;
               step_in = ST_ARISE; wait_in = phase_m1;
            end
            default: begin
            end
         endcase
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - BYTE_W'(1);
      end else begin
         unique case (step_ff)
            ST_START1: begin
               sda_in_lvl = 1'b0; step_in = ST_START2; wait_in = phase_m1;
            end
            ST_START2: begin
               scl_in = 1'b0; step_in = ST_IDLE; wait_in = '0;
            end
            ST_STOP1: begin
               scl_in = 1'b1; step_in = ST_STOP2; wait_in = phase_m1;
            end
            ST_STOP2: begin
               sda_in_lvl = 1'b1; step_in = ST_IDLE; wait_in = '0;
            end
            ST_WRISE: begin
               scl_in = 1'b1; step_in = ST_WFALL; wait_in = phase_m1;
            end
            ST_WFALL: begin
               scl_in = 1'b0; step_in = ST_WNEXT; wait_in = phase_m1;
            end
            ST_WNEXT: begin
               bit_in = bit_inc;
               if (bit_inc < BITS_PER_BYTE) begin
                  sda_in_lvl = shift_ff[BYTE_W-1];
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                  step_in = ST_WRISE; wait_in = phase_m1;
               end else begin
                  step_in = ST_IDLE; wait_in = '0;
               end
            end
            ST_RRISE: begin
               scl_in = 1'b1; step_in = ST_RSAMPLE; wait_in = sample_m1;
            end
            ST_RSAMPLE: begin
               shift_in = {shift_ff[BYTE_W-2:0], req_sda};
               if (eff_phase > eff_sample) begin
                  step_in = ST_RFALL; wait_in = extra_m1;
               end else begin
                  scl_in = 1'b0; step_in = ST_RNEXT; wait_in = phase_m1;
               end
            end
            ST_RFALL: begin
               scl_in = 1'b0; step_in = ST_RNEXT; wait_in = phase_m1;
            end
            ST_RNEXT: begin
               bit_in = bit_inc;
               if (bit_inc < BITS_PER_BYTE) begin
                  scl_in = 1'b1; step_in = ST_RSAMPLE; wait_in = sample_m1;
               end else begin
                  drive_in = 1'b1; rx_hold_in = shift_ff; rx_valid_in = 1'b1;
                  step_in = ST_IDLE; wait_in = '0;
               end
            end
            ST_ARISE: begin
               scl_in = 1'b1; step_in = ST_AFALL; wait_in = phase_m1;
            end
            ST_AFALL: begin
               scl_in = 1'b0; step_in = ST_ADONE; wait_in = phase_m1;
            end
            default: begin
               step_in = ST_IDLE; wait_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_RESET;
         sample_ff <= SAMPLE_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_PHASE:  phase_ff  <= csr_wdata;
            CSR_SAMPLE: sample_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drive_ff     <= 1'b1;
         step_ff      <= ST_IDLE;
         bit_ff       <= '0;
         wait_ff      <= '0;
         shift_ff     <= '0;
         rx_hold_ff   <= '0;
         rx_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            scl_ff      <= scl_in;
            sda_ff      <= sda_in_lvl;
            drive_ff    <= drive_in;
            step_ff     <= step_in;
            bit_ff      <= bit_in;
            wait_ff     <= wait_in;
            shift_ff    <= shift_in;
            rx_hold_ff  <= rx_hold_in;
            rx_valid_ff <= rx_valid_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rx_valid_ff, rx_hold_ff, (step_ff != ST_IDLE),
                        drive_ff, sda_ff, scl_ff};

   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_IDLE) |-> (wait_ff == '0))
      else $error("wait counter left running while idle");

   a_release_in_read: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> (step_ff == ST_RRISE || step_ff == ST_RSAMPLE ||
                     step_ff == ST_RFALL || step_ff == ST_RNEXT))
      else $error("SDA released outside a read");

   a_rx_done_idle: assert property (@(posedge clock) disable iff (reset)
      rx_valid_ff |-> (step_ff == ST_IDLE && drive_ff))
      else $error("read completion while sequence still running");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && step_ff == ST_IDLE && scl_ff && sda_ff))
      else $error("engine not idle with lines high after reset");

endmodule

[verif/sccb_master_bit_engine_top_tb.sv]
// ---------------------------------------------------------------------------
// SCCB master bit engine testbench
// Each request is one timebase tick. The bench runs a short table of directed
// requests and then random bus transactions (start, write, read, ack, stop)
// under several phase and sample timings, from the slowest to zero values.
// While a command runs, requests carry noise and fixed or random SDA levels.
// A line-level model of the engine predicts every response, and each
// response is compared field by field. Both sides of the stream stall at
// random, and the timing registers are written only while the engine is idle.
// ---------------------------------------------------------------------------
module sccb_master_bit_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sccbbe_pkg::*;

   typedef struct packed {
      logic [2:0]        pad;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_data;
      logic              busy;
      logic              sda_oe;
      logic              sda_out;
      logic              scl;
   } line_t;

   typedef struct packed {
      logic [3:0]        pad;
      logic              sda_in;
      logic [BYTE_W-1:0] tx_data;
      logic [OP_W-1:0]   op;
   } tick_t;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] tx;
      logic              sda;
      logic [OP_W-1:0]   fill_op;
      logic [1:0]        fill_sda;
      logic              typed;
      line_t             want;
   } dir_row_t;

   typedef struct packed {
      logic [BYTE_W-1:0] phase;
      logic [BYTE_W-1:0] sample;
      int unsigned       commands;
      int unsigned       snd_pct;
      int unsigned       rcv_pct;
   } timing_t;

   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
   localparam logic [1:0]      SDA_LOW  = 2'd0;
   localparam logic [1:0]      SDA_HIGH = 2'd1;
   localparam logic [1:0]      SDA_RAND = 2'd2;
   localparam int unsigned     LIMIT_CYCLES = 2_500_000;

   localparam line_t LINES_IDLE = '{pad: 3'b0, rx_valid: 1'b0, rx_data: 8'h00, busy: 1'b0,
                                    sda_oe: 1'b1, sda_out: 1'b1, scl: 1'b1};
   localparam line_t LINES_START = '{pad: 3'b0, rx_valid: 1'b0, rx_data: 8'h00, busy: 1'b1,
                                     sda_oe: 1'b1, sda_out: 1'b1, scl: 1'b1};

   localparam dir_row_t DIRECTED [14] = '{
      '{OP_NONE,  8'h00, 1'b0, OP_NONE,  SDA_LOW,  1'b1, LINES_IDLE},
      '{OP_RSVD6, 8'hFF, 1'b1, OP_NONE,  SDA_LOW,  1'b1, LINES_IDLE},
      '{OP_RSVD7, 8'h00, 1'b0, OP_NONE,  SDA_LOW,  1'b1, LINES_IDLE},
      '{OP_START, 8'h00, 1'b0, OP_STOP,  SDA_RAND, 1'b1, LINES_START},
      '{OP_WRITE, 8'hFF, 1'b0, OP_READ,  SDA_RAND, 1'b0, LINES_IDLE},
      '{OP_WRITE, 8'h00, 1'b1, OP_WRITE, SDA_RAND, 1'b0, LINES_IDLE},
      '{OP_WRITE, 8'hA5, 1'b1, OP_ACK,   SDA_HIGH, 1'b0, LINES_IDLE},
      '{OP_WRITE, 8'h5A, 1'b0, OP_RSVD7, SDA_LOW,  1'b0, LINES_IDLE},
      '{OP_READ,  8'h3C, 1'b0, OP_START, SDA_RAND, 1'b0, LINES_IDLE},
      '{OP_READ,  8'h00, 1'b1, OP_RSVD6, SDA_HIGH, 1'b0, LINES_IDLE},
      '{OP_ACK,   8'hC3, 1'b1, OP_READ,  SDA_RAND, 1'b0, LINES_IDLE},
      '{OP_READ,  8'hFF, 1'b0, OP_WRITE, SDA_LOW,  1'b0, LINES_IDLE},
      '{OP_STOP,  8'h81, 1'b0, OP_ACK,   SDA_RAND, 1'b0, LINES_IDLE},
      '{OP_NONE,  8'h7E, 1'b1, OP_NONE,  SDA_LOW,  1'b1, LINES_IDLE}
   };

   localparam timing_t TIMINGS [9] = '{
      '{8'd1,   8'd1,   8, 29, 87},
      '{8'd0,   8'd0,   6, 29, 87},
      '{8'd2,   8'd1,   4, 29, 87},
      '{8'd3,   8'd2,   3, 87, 29},
      '{8'd1,   8'd255, 1, 87, 29},
      '{8'd4,   8'd2,   2, 87, 29},
      '{8'd255, 8'd1,   1, 0,  0},
      '{8'd2,   8'd5,   4, 0,  0},
      '{8'd1,   8'd3,   5, 0,  0}
   };

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata   = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wen     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_PHASE;
   logic [BYTE_W-1:0]    csr_wdata   = '0;

   int unsigned snd_idle_pct = 29;
   int unsigned rcv_idle_pct = 87;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   line_t       expected_lines [$];

   // Line engine model state.
   logic [BYTE_W-1:0] phase_cfg, sample_cfg;
   logic              scl_q, sda_q, oe_q;
   step_type          step_q;
   logic [CNT_W-1:0]  bits_q;
   logic [BYTE_W-1:0] wait_q, shift_q, rx_q;

   sccb_master_bit_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] at_least_one(input logic [BYTE_W-1:0] v);
      return (v == '0) ? 8'd1 : v;
   endfunction

   function automatic logic engine_busy();
      return step_q != ST_IDLE;
   endfunction

   task automatic hold_then(input step_type nxt, input logic [BYTE_W-1:0] n);
      step_q = nxt;
      wait_q = n - 8'd1;
   endtask

   task automatic to_idle();
      step_q = ST_IDLE;
      wait_q = '0;
   endtask

   task automatic emit_bit();
      sda_q   = shift_q[BYTE_W-1];
      shift_q = {shift_q[BYTE_W-2:0], 1'b0};
      hold_then(ST_WRISE, at_least_one(phase_cfg));
   endtask

   task automatic read_rise();
      scl_q = 1'b1;
      hold_then(ST_RSAMPLE, at_least_one(sample_cfg));
   endtask

   task automatic read_fall();
      scl_q = 1'b0;
      hold_then(ST_RNEXT, at_least_one(phase_cfg));
   endtask

   task automatic engine_reset_state();
      phase_cfg  = PHASE_RESET;
      sample_cfg = SAMPLE_RESET;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      oe_q       = 1'b1;
      step_q     = ST_IDLE;
      bits_q     = '0;
      wait_q     = '0;
      shift_q    = '0;
      rx_q       = '0;
   endtask

   task automatic advance_line_engine(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                                      input logic sda, output line_t res);
      logic              done_read;
      logic [BYTE_W-1:0] ph, sm;
      done_read = 1'b0;
      ph = at_least_one(phase_cfg);
      sm = at_least_one(sample_cfg);
      if (step_q == ST_IDLE) begin
         bits_q = '0;
         case (op)
            OP_START: begin
               scl_q = 1'b1;
               sda_q = 1'b1;
               hold_then(ST_START1, ph);
            end
            OP_STOP: begin
               scl_q = 1'b0;
               sda_q = 1'b0;
               hold_then(ST_STOP1, ph);
            end
            OP_WRITE: begin
               scl_q   = 1'b0;
               shift_q = tx;
               emit_bit();
            end
            OP_READ: begin
               oe_q    = 1'b0;
               scl_q   = 1'b0;
               shift_q = '0;
               hold_then(ST_RRISE, ph);
            end
            OP_ACK: begin
               scl_q = 1'b0;
               sda_q = 1'b0;
               hold_then(ST_ARISE, ph);
            end
            default: to_idle();
         endcase
      end else if (wait_q != '0) begin
         wait_q = wait_q - 8'd1;
      end else begin
         case (step_q)
            ST_START1: begin
               sda_q = 1'b0;
               hold_then(ST_START2, ph);
            end
            ST_START2: begin
               scl_q = 1'b0;
               to_idle();
            end
            ST_STOP1: begin
               scl_q = 1'b1;
               hold_then(ST_STOP2, ph);
            end
            ST_STOP2: begin
               sda_q = 1'b1;
               to_idle();
            end
            ST_WRISE: begin
               scl_q = 1'b1;
               hold_then(ST_WFALL, ph);
            end
            ST_WFALL: begin
               scl_q = 1'b0;
               hold_then(ST_WNEXT, ph);
            end
            ST_WNEXT: begin
               bits_q = bits_q + 4'd1;
               if (bits_q < BITS_PER_BYTE) emit_bit();
               else to_idle();
            end
            ST_RRISE: read_rise();
            ST_RSAMPLE: begin
               shift_q = {shift_q[BYTE_W-2:0], sda};
               if (ph > sm) hold_then(ST_RFALL, ph - sm);
               else read_fall();
            end
            ST_RFALL: read_fall();
            ST_RNEXT: begin
               bits_q = bits_q + 4'd1;
               if (bits_q < BITS_PER_BYTE) begin
                  read_rise();
               end else begin
                  oe_q      = 1'b1;
                  rx_q      = shift_q;
                  done_read = 1'b1;
                  to_idle();
               end
            end
            ST_ARISE: begin
               scl_q = 1'b1;
               hold_then(ST_AFALL, ph);
            end
            ST_AFALL: begin
               scl_q = 1'b0;
               hold_then(ST_ADONE, ph);
            end
            default: to_idle();
         endcase
      end
      res = '{pad: 3'b0, rx_valid: done_read, rx_data: rx_q, busy: engine_busy(),
              sda_oe: oe_q, sda_out: sda_q, scl: scl_q};
   endtask

   task automatic note_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (mismatch_count < 100)
         $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_tick(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                            input logic sda, input logic typed, input line_t want);
      line_t predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tick_t'{pad: 4'b0, sda_in: sda, tx_data: tx, op: op};
      do @(posedge clock); while (!req_tready);
      advance_line_engine(op, tx, sda, predicted);
      expected_lines.push_back(typed ? want : predicted);
   endtask

   task automatic quiesce();
      while (engine_busy())
         send_tick(OP_NONE, BYTE_W'($urandom), 1'($urandom_range(1)), 1'b0, LINES_IDLE);
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timing(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] s);
      csr_wen   <= 1'b1;
      csr_index <= CSR_PHASE;
      csr_wdata <= p;
      @(posedge clock);
      phase_cfg = p;
      csr_index <= CSR_SAMPLE;
      csr_wdata <= s;
      @(posedge clock);
      sample_cfg = s;
      csr_wen <= 1'b0;
   endtask

   task automatic run_transactions(input int unsigned commands);
      logic [OP_W-1:0] plan [$];
      logic [OP_W-1:0] op;
      int unsigned     launched;
      launched = 0;
      while (launched < commands) begin
         if (engine_busy()) begin
            if ($urandom_range(1)) op = OP_NONE;
            else op = OP_W'($urandom_range(7));
         end else begin
            if (plan.size() == 0) begin
               if ($urandom_range(99) < 85) begin
                  plan.push_back(OP_START);
                  plan.push_back(OP_WRITE);
                  repeat ($urandom_range(3)) begin
                     if ($urandom_range(1)) begin
                        plan.push_back(OP_WRITE);
                     end else begin
                        plan.push_back(OP_READ);
                        if ($urandom_range(1)) plan.push_back(OP_ACK);
                     end
                  end
                  if ($urandom_range(3) == 0) plan.push_back(OP_NONE);
                  plan.push_back(OP_STOP);
               end else begin
                  plan.push_back(OP_W'($urandom_range(7)));
               end
            end
            op = plan.pop_front();
            if (op >= OP_START && op <= OP_ACK) launched++;
         end
         send_tick(op, BYTE_W'($urandom), 1'($urandom_range(1)), 1'b0, LINES_IDLE);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin : response_check
      line_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_lines.size() == 0) begin
            note_mismatch("unexpected response", got, 0);
         end else begin
            want = expected_lines.pop_front();
            if (got.scl !== want.scl) note_mismatch("scl", got.scl, want.scl);
            if (got.sda_out !== want.sda_out) note_mismatch("sda_out", got.sda_out, want.sda_out);
            if (got.sda_oe !== want.sda_oe) note_mismatch("sda_oe", got.sda_oe, want.sda_oe);
            if (got.busy !== want.busy) note_mismatch("busy_res", got.busy, want.busy);
            if (got.rx_data !== want.rx_data) note_mismatch("rx_data", got.rx_data, want.rx_data);
            if (got.rx_valid !== want.rx_valid)
               note_mismatch("rx_valid", got.rx_valid, want.rx_valid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL sccb_master_bit_engine_top");
         $finish;
      end
   end

   initial begin
      engine_reset_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_tick(DIRECTED[i].op, DIRECTED[i].tx, DIRECTED[i].sda, DIRECTED[i].typed,
                   DIRECTED[i].want);
         while (engine_busy())
            send_tick(DIRECTED[i].fill_op, BYTE_W'($urandom),
                      (DIRECTED[i].fill_sda == SDA_RAND) ? 1'($urandom_range(1))
                                                         : DIRECTED[i].fill_sda[0],
                      1'b0, LINES_IDLE);
      end

      foreach (TIMINGS[i]) begin
         quiesce();
         snd_idle_pct = TIMINGS[i].snd_pct;
         rcv_idle_pct = TIMINGS[i].rcv_pct;
         set_timing(TIMINGS[i].phase, TIMINGS[i].sample);
         run_transactions(TIMINGS[i].commands);
      end
      quiesce();

      if (mismatch_count == 0) begin
         $display("PASS sccb_master_bit_engine_top");
      end else begin
         $display("FAIL sccb_master_bit_engine_top");
      end
      $finish;
   end

endmodule

[files.f]
src/sccbbe_pkg.sv
src/sccb_master_bit_engine_top.sv
verif/sccb_master_bit_engine_top_tb.sv
